/* sv/life_generation_engine_assert.svh */
// Assertion macros shared by the checker files of the life generation engine.
// Expects clk_i and rst_ni to be in scope where a macro is used.
`ifndef LIFE_GENERATION_ENGINE_ASSERT_SVH
`define LIFE_GENERATION_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define LGE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lge: implication check failed");

// Next-cycle implication, disabled while in reset
`define LGE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lge: next-cycle check failed");

`endif

/* sv/lge_pkg.sv */
// Shared types and constants for the life generation engine.
// No dependencies.
package lge_pkg;

  // Item action codes; code 3 is unused and yields an empty result
  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_ADVANCE = 2'd1;
  localparam logic [1:0] ACT_READ    = 2'd2;

  // B3/S23 rule
  localparam int unsigned NBR_W = 4;
  localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;
  localparam logic [NBR_W-1:0] BIRTH_COUNT   = 4'd3;

  // One cell and its eight neighbours, as handed to the rule unit
  typedef struct packed {
    logic       alive;
    logic [7:0] nbrs;
  } nbhd_t;

endpackage

/* sv/lge_row_mem.sv */
// Row-wide grid memory: one write port, one read port with registered data.
// No dependencies.
module lge_row_mem #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 48,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/lge_cell_unit.sv */
// Shared rule unit: counts the eight neighbours and applies B3/S23.
// Depends on lge_pkg.
module lge_cell_unit (
  input  lge_pkg::nbhd_t nbhd_i,
  output logic           next_alive_o
);

  logic [lge_pkg::NBR_W-1:0] count;

  always_comb begin
    count = '0;
    for (int i = 0; i < 8; i++) begin
      count = count + lge_pkg::NBR_W'(nbhd_i.nbrs[i]);
    end
  end

  assign next_alive_o = (count == lge_pkg::BIRTH_COUNT) ||
                        (nbhd_i.alive && (count == lge_pkg::SURVIVE_COUNT));

endmodule

/* sv/life_generation_engine.sv */
// Top level of the life generation engine: sequencer, row window and grid banks.
// Depends on lge_pkg, lge_row_mem and lge_cell_unit.
//
// Holds a GRID_ROWS x GRID_COLUMNS grid of one-bit cells, stored one row per word in
// two banks that swap roles on each advance. An item is taken when start is high and
// busy is low; its one result appears on done_o for a single cycle and cannot be held
// off. A cell write or read passes through the access state; an unused action or an
// address off the grid is answered straight from idle. An advance runs one cell a cycle
// through the shared rule unit, plus a row fetch and a window shift per row, one pair
// more to prime the window; rows come in through the single memory read port. After
// reset the live bank is cleared row by row, and busy stays high until that is done.
module life_generation_engine #(
  parameter int GRID_COLUMNS = 80,
  parameter int GRID_ROWS    = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [4:0]  row_i,
  input  logic [6:0]  column_i,
  input  logic        cell_in_i,
  output logic        done_o,
  output logic        cell_out_o,
  output logic [15:0] generation_number_o
);

  localparam int CW    = $clog2(GRID_COLUMNS);
  localparam int RW    = $clog2(GRID_ROWS);
  localparam int DEPTH = 2 * GRID_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = $clog2(GRID_ROWS + 2);

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_CLEAR     = 7'b0000010,
    ST_ACCESS    = 7'b0000100,
    ST_FETCH     = 7'b0001000,
    ST_SHIFT     = 7'b0010000,
    ST_CELL      = 7'b0100000,
    ST_SPARE     = 7'b1000000
  } state_e;

  state_e                  state_q;
  logic                    live_bank_q;
  logic [RW-1:0]           clr_q;
  logic [RW-1:0]           row_q;
  logic [RW-1:0]           out_row_q;
  logic [CW-1:0]           col_q;
  logic [FW-1:0]           fetch_q;
  logic                    cell_q;
  logic                    is_write_q;
  logic                    done_q;
  logic                    cell_out_q;
  logic [15:0]             gen_q;
  logic [GRID_COLUMNS-1:0] prev_q, cur_q, next_q, new_row_q;

  logic                    done_d;
  logic                    on_grid;
  logic                    fetch_in;
  logic                    last_col;
  logic                    last_row;
  logic                    l_ok, r_ok;
  logic [CW-1:0]           col_m1, col_p1;
  logic [GRID_COLUMNS-1:0] new_row_d;
  logic [GRID_COLUMNS-1:0] merged;
  logic                    next_alive;
  lge_pkg::nbhd_t          nbhd;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr, mem_raddr;
  logic [GRID_COLUMNS-1:0] mem_wdata, mem_rdata;

  function automatic logic [AW-1:0] bank_addr(logic bank, logic [RW-1:0] r);
    bank_addr = bank ? (AW'(GRID_ROWS) + AW'(r)) : AW'(r);
  endfunction

  assign on_grid  = (int'(row_i) < GRID_ROWS) && (int'(column_i) < GRID_COLUMNS);
  assign fetch_in = fetch_q < FW'(GRID_ROWS);
  assign last_col = col_q == CW'(GRID_COLUMNS - 1);
  assign last_row = out_row_q == RW'(GRID_ROWS - 1);

  // 3x3 window around col_q; off-grid neighbours read as dead
  assign l_ok   = col_q != '0;
  assign r_ok   = !last_col;
  assign col_m1 = col_q - CW'(1);
  assign col_p1 = col_q + CW'(1);

  always_comb begin
    nbhd.alive = cur_q[col_q];
    nbhd.nbrs  = {l_ok & prev_q[col_m1], prev_q[col_q], r_ok & prev_q[col_p1],
                  l_ok & cur_q[col_m1],                 r_ok & cur_q[col_p1],
                  l_ok & next_q[col_m1], next_q[col_q], r_ok & next_q[col_p1]};
  end

  lge_cell_unit u_rule (
    .nbhd_i       (nbhd),
    .next_alive_o (next_alive)
  );

  always_comb begin
    new_row_d        = new_row_q;
    new_row_d[col_q] = next_alive;
    merged           = mem_rdata;
    merged[col_q]    = cell_q;
  end

  // Memory ports
  always_comb begin
    if (state_q == ST_IDLE) begin
      mem_raddr = bank_addr(live_bank_q, RW'(row_i));
    end else begin
      mem_raddr = bank_addr(live_bank_q, fetch_in ? fetch_q[RW-1:0] : '0);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = bank_addr(1'b0, clr_q);
      end
      ST_ACCESS: begin
        mem_we    = is_write_q;
        mem_waddr = bank_addr(live_bank_q, row_q);
        mem_wdata = merged;
      end
      ST_CELL: begin
        mem_we    = last_col;
        mem_waddr = bank_addr(!live_bank_q, out_row_q);
        mem_wdata = new_row_d;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  lge_row_mem #(
    .WIDTH (GRID_COLUMNS),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Result strobe: at once for an off-grid or unused word, after the memory
  // cycle for a cell access, after the last cell of an advance
  always_comb begin
    done_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (action_i)
            lge_pkg::ACT_WRITE, lge_pkg::ACT_READ: done_d = !on_grid;
            lge_pkg::ACT_ADVANCE:                  done_d = 1'b0;
            default:                               done_d = 1'b1;
          endcase
        end
      end
      ST_ACCESS: done_d = 1'b1;
      ST_CELL:   done_d = last_col && last_row;
      default:   done_d = 1'b0;
    endcase
  end

  // Sequencer and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      live_bank_q <= 1'b0;
      clr_q       <= '0;
      out_row_q   <= '0;
      col_q       <= '0;
      fetch_q     <= '0;
      is_write_q  <= 1'b0;
      done_q      <= 1'b0;
      cell_out_q  <= 1'b0;
      gen_q       <= '0;
    end else begin
      done_q <= done_d;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + RW'(1);
          if (clr_q == RW'(GRID_ROWS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            cell_out_q <= 1'b0;
            case (action_i)
              lge_pkg::ACT_WRITE, lge_pkg::ACT_READ: begin
                is_write_q <= action_i == lge_pkg::ACT_WRITE;
                col_q      <= CW'(column_i);
                if (on_grid) begin
                  state_q <= ST_ACCESS;
                end
              end
              lge_pkg::ACT_ADVANCE: begin
                fetch_q   <= '0;
                out_row_q <= '0;
                col_q     <= '0;
                state_q   <= ST_FETCH;
              end
              default: ;
            endcase
          end
        end
        ST_ACCESS: begin
          if (!is_write_q) begin
            cell_out_q <= mem_rdata[col_q];
          end
          state_q <= ST_IDLE;
        end
        ST_FETCH: begin
          state_q <= ST_SHIFT;
        end
        ST_SHIFT: begin
          fetch_q <= fetch_q + FW'(1);
          // two shifts prime the window before the first row is computed
          state_q <= (fetch_q != '0) ? ST_CELL : ST_FETCH;
        end
        ST_CELL: begin
          if (last_col) begin
            col_q <= '0;
            if (last_row) begin
              live_bank_q <= !live_bank_q;
              gen_q       <= gen_q + 16'd1;
              state_q     <= ST_IDLE;
            end else begin
              out_row_q <= out_row_q + RW'(1);
              state_q   <= ST_FETCH;
            end
          end else begin
            col_q <= col_q + CW'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Row window and item fields
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      row_q  <= RW'(row_i);
      cell_q <= cell_in_i;
      prev_q <= '0;
      cur_q  <= '0;
      next_q <= '0;
    end
    if (state_q == ST_SHIFT) begin
      prev_q <= cur_q;
      cur_q  <= next_q;
      next_q <= fetch_in ? mem_rdata : '0;
    end
    if (state_q == ST_CELL) begin
      new_row_q <= new_row_d;
    end
  end

  assign busy                = state_q != ST_IDLE;
  assign done_o              = done_q;
  assign cell_out_o          = cell_out_q;
  assign generation_number_o = gen_q;

endmodule

/* sv/lge_checker.sv */
// Port-level checker for the life generation engine, bound to the top level.
// Depends on life_generation_engine_assert.svh.
`include "life_generation_engine_assert.svh"

module lge_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  action_i,
  input logic [4:0]  row_i,
  input logic [6:0]  column_i,
  input logic        cell_in_i,
  input logic        done_o,
  input logic        cell_out_o,
  input logic [15:0] generation_number_o
);

  // an accepted word is either answered next cycle or keeps the engine busy
  `LGE_ASSERT_NXT(a_accept_progress, start && !busy, busy || done_o)
  // a result is shown only as the engine returns to idle
  `LGE_ASSERT_IMP(a_done_idle, done_o, !busy)
  // the generation count moves only with a result
  `LGE_ASSERT_IMP(a_gen_hold, !done_o, $stable(generation_number_o))
  // and then by exactly one
  `LGE_ASSERT_IMP(a_gen_step, done_o && !$stable(generation_number_o),
                  generation_number_o == $past(generation_number_o) + 16'd1)

endmodule

bind life_generation_engine lge_checker u_lge_checker (.*);

/* test/life_generation_engine_checker.sv */
`timescale 1ns / 1ps
// Result checker for the life generation engine: keeps a shadow grid and generation count,
// works out each cell report and compares it with what the block returns.
// Depends on lge_pkg.
module life_generation_engine_checker #(
  parameter int GRID_COLUMNS = 80,
  parameter int GRID_ROWS    = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  action_i,
  input  logic [4:0]  row_i,
  input  logic [6:0]  column_i,
  input  logic        cell_in_i,
  input  logic        done_o,
  input  logic        cell_out_o,
  input  logic [15:0] generation_number_o,
  output int          mismatch_count_o,
  output int          reports_due_o
);

  typedef struct packed {
    logic        cell_out;
    logic [15:0] generation;
  } cell_report_t;

  logic [GRID_COLUMNS-1:0] shadow_grid [GRID_ROWS];
  logic [15:0]             shadow_generation;
  cell_report_t            due_reports [$];
  cell_report_t            oldest_report;
  cell_report_t            new_report;

  // off-grid neighbours read as dead, no wrap-around
  function automatic logic shadow_cell(int r, int c);
    if (r < 0 || r >= GRID_ROWS || c < 0 || c >= GRID_COLUMNS) return 1'b0;
    return shadow_grid[r][c];
  endfunction

  task automatic advance_shadow();
    logic [GRID_COLUMNS-1:0] next_grid [GRID_ROWS];
    int n;
    for (int r = 0; r < GRID_ROWS; r++) begin
      for (int c = 0; c < GRID_COLUMNS; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++)
          for (int dc = -1; dc <= 1; dc++)
            if (dr != 0 || dc != 0) n += shadow_cell(r + dr, c + dc);
        next_grid[r][c] = (n == lge_pkg::BIRTH_COUNT) ||
                          (shadow_grid[r][c] && n == lge_pkg::SURVIVE_COUNT);
      end
    end
    shadow_grid = next_grid;
    shadow_generation = shadow_generation + 16'd1;
  endtask

  task automatic take_word(input logic [1:0] act, input logic [4:0] r, input logic [6:0] c,
                           input logic v, output cell_report_t rep);
    logic on_grid;
    on_grid = (r < GRID_ROWS) && (c < GRID_COLUMNS);
    rep.cell_out = 1'b0;
    case (act)
      lge_pkg::ACT_WRITE:   if (on_grid) shadow_grid[r][c] = v;
      lge_pkg::ACT_ADVANCE: advance_shadow();
      lge_pkg::ACT_READ:    if (on_grid) rep.cell_out = shadow_grid[r][c];
      default: ;
    endcase
    rep.generation = shadow_generation;
  endtask

  // Sampled mid-cycle: inputs change on the rising edge, so everything is settled here.
  // A word seen with start high and busy low is taken at the next rising edge.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      foreach (shadow_grid[r]) shadow_grid[r] = '0;
      shadow_generation = '0;
      due_reports.delete();
    end else begin
      if (done_o === 1'b1) begin
        if (due_reports.size() == 0) begin
          $display("%0t: result with none expected: cell_out=%0b generation_number=%0d",
                   $time, cell_out_o, generation_number_o);
          mismatch_count_o++;
        end else begin
          oldest_report = due_reports.pop_front();
          if (cell_out_o !== oldest_report.cell_out) begin
            $display("%0t: cell_out expected %0b actual %0b",
                     $time, oldest_report.cell_out, cell_out_o);
            mismatch_count_o++;
          end
          if (generation_number_o !== oldest_report.generation) begin
            $display("%0t: generation_number expected %0d actual %0d",
                     $time, oldest_report.generation, generation_number_o);
            mismatch_count_o++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        take_word(action_i, row_i, column_i, cell_in_i, new_report);
        due_reports.push_back(new_report);
      end
    end
    reports_due_o = due_reports.size();
  end

endmodule

/* test/life_generation_engine_tb.sv */
`timescale 1ns / 1ps
// Top of the life generation engine testbench: clock, reset, directed and random words.
// Depends on lge_pkg, life_generation_engine and life_generation_engine_checker.
module life_generation_engine_tb;

  localparam int ROWS = 24;
  localparam int COLS = 80;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  action_i = lge_pkg::ACT_WRITE;
  logic [4:0]  row_i = '0;
  logic [6:0]  column_i = '0;
  logic        cell_in_i = 1'b0;
  logic        done_o;
  logic        cell_out_o;
  logic [15:0] generation_number_o;

  int mismatches;
  int reports_due;
  int words_sent = 0;
  bit steady = 1'b0;
  bit held_once = 1'b0;

  life_generation_engine #(
    .GRID_COLUMNS(COLS),
    .GRID_ROWS   (ROWS)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .action_i           (action_i),
    .row_i              (row_i),
    .column_i           (column_i),
    .cell_in_i          (cell_in_i),
    .done_o             (done_o),
    .cell_out_o         (cell_out_o),
    .generation_number_o(generation_number_o)
  );

  life_generation_engine_checker #(
    .GRID_COLUMNS(COLS),
    .GRID_ROWS   (ROWS)
  ) checker_i (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .action_i           (action_i),
    .row_i              (row_i),
    .column_i           (column_i),
    .cell_in_i          (cell_in_i),
    .done_o             (done_o),
    .cell_out_o         (cell_out_o),
    .generation_number_o(generation_number_o),
    .mismatch_count_o   (mismatches),
    .reports_due_o      (reports_due)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // worst case is every word an advance, plus gaps
  initial begin
    #30_000_000;
    $display("FAIL life_generation_engine");
    $finish;
  end

  // Returns at the rising edge that took the word; start is left high for the next one.
  task automatic send_word(input logic [1:0] act, input int r, input int c, input int v);
    if (!steady && $urandom_range(99) < 17) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start     <= 1'b1;
    action_i  <= act;
    row_i     <= 5'(r);
    column_i  <= 7'(c);
    cell_in_i <= 1'(v);
    do @(negedge clk_i); while (busy !== 1'b0);
    @(posedge clk_i);
    if (act == lge_pkg::ACT_ADVANCE || (act != ACT_UNUSED && r < ROWS && c < COLS))
      words_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (reports_due != 0) @(posedge clk_i);
  endtask

  // a cell within two of base, kept on the grid
  function automatic int nudge(int base, int limit);
    int v;
    v = base + int'($urandom_range(4)) - 2;
    if (v < 0) v = 0;
    if (v > limit - 1) v = limit - 1;
    return v;
  endfunction

  // seed a small area (often at an edge), let it evolve, then look at it; now and then add an off-grid or unused word
  task automatic run_episode();
    int fr, fc, gr, gc;
    case ($urandom_range(3))
      0:       fr = $urandom_range(1);
      1:       fr = ROWS - 1 - int'($urandom_range(1));
      default: fr = $urandom_range(ROWS - 1);
    endcase
    case ($urandom_range(3))
      0:       fc = $urandom_range(1);
      1:       fc = COLS - 1 - int'($urandom_range(1));
      default: fc = $urandom_range(COLS - 1);
    endcase
    if ($urandom_range(3) == 0) begin
      // glider
      gr = (fr > ROWS - 3) ? ROWS - 3 : fr;
      gc = (fc > COLS - 3) ? COLS - 3 : fc;
      send_word(lge_pkg::ACT_WRITE, gr,     gc + 1, 1);
      send_word(lge_pkg::ACT_WRITE, gr + 1, gc + 2, 1);
      send_word(lge_pkg::ACT_WRITE, gr + 2, gc,     1);
      send_word(lge_pkg::ACT_WRITE, gr + 2, gc + 1, 1);
      send_word(lge_pkg::ACT_WRITE, gr + 2, gc + 2, 1);
    end else begin
      repeat ($urandom_range(2, 8))
        send_word(lge_pkg::ACT_WRITE, nudge(fr, ROWS), nudge(fc, COLS),
                  $urandom_range(99) < 65);
    end
    repeat ($urandom_range(0, 3))
      send_word(lge_pkg::ACT_ADVANCE, $urandom_range(31), $urandom_range(127),
                $urandom_range(1));
    repeat ($urandom_range(2, 8))
      send_word(lge_pkg::ACT_READ, nudge(fr, ROWS), nudge(fc, COLS), $urandom_range(1));
    if ($urandom_range(99) < 20) begin
      case ($urandom_range(2))
        0: send_word(ACT_UNUSED, $urandom_range(31), $urandom_range(127), $urandom_range(1));
        1: send_word(lge_pkg::ACT_WRITE, $urandom_range(24, 31), $urandom_range(127), 1);
        default: send_word(lge_pkg::ACT_READ, $urandom_range(31), $urandom_range(80, 127),
                           $urandom_range(1));
      endcase
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corners, off-grid addresses, unused code, blinker against the top edge
    send_word(lge_pkg::ACT_WRITE,   0,  0,   1);
    send_word(lge_pkg::ACT_WRITE,   23, 79,  1);
    send_word(lge_pkg::ACT_WRITE,   0,  79,  1);
    send_word(lge_pkg::ACT_WRITE,   23, 0,   1);
    send_word(lge_pkg::ACT_READ,    0,  0,   1);
    send_word(lge_pkg::ACT_READ,    23, 79,  0);
    send_word(lge_pkg::ACT_READ,    0,  79,  0);
    send_word(lge_pkg::ACT_READ,    23, 0,   0);
    send_word(lge_pkg::ACT_WRITE,   24, 0,   1);
    send_word(lge_pkg::ACT_WRITE,   31, 127, 1);
    send_word(lge_pkg::ACT_READ,    31, 127, 0);
    send_word(lge_pkg::ACT_READ,    0,  80,  0);
    send_word(lge_pkg::ACT_READ,    24, 5,   0);
    send_word(ACT_UNUSED,           5,  5,   1);
    send_word(lge_pkg::ACT_WRITE,   0,  39,  1);
    send_word(lge_pkg::ACT_WRITE,   0,  40,  1);
    send_word(lge_pkg::ACT_WRITE,   0,  41,  1);
    send_word(lge_pkg::ACT_ADVANCE, 31, 127, 1);
    send_word(lge_pkg::ACT_READ,    0,  40,  0);
    send_word(lge_pkg::ACT_READ,    1,  40,  0);
    send_word(lge_pkg::ACT_READ,    0,  39,  0);
    send_word(lge_pkg::ACT_READ,    0,  0,   0);
    send_word(lge_pkg::ACT_WRITE,   0,  40,  0);
    send_word(lge_pkg::ACT_READ,    0,  40,  1);
    send_word(lge_pkg::ACT_ADVANCE, 0,  0,   0);

    words_sent = 0;
    while (words_sent < 300) begin
      steady = (words_sent >= 120 && words_sent < 180);
      if (!held_once && words_sent >= 100) begin
        drain_results();
        held_once = 1'b1;
      end
      run_episode();
    end
    steady = 1'b0;

    drain_results();
    // catch any stray result after the last expected one
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS life_generation_engine");
    end else begin
      $display("FAIL life_generation_engine");
    end
    $finish;
  end

endmodule
